[hdl/arxsk_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arxsk_pkg
// Shared types, constants and helpers for the ARX subkey derivation block.
// ----------------------------------------------------------------------------
package arxsk_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned NUM_WORDS   = 16;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned SETS_PER_DR = 8;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;
  typedef logic [3:0] widx_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_KEY_A = 2'd0,
    CFG_KEY_B = 2'd1,
    CFG_KEY_C = 2'd2,
    CFG_KEY_D = 2'd3
  } cfg_idx_t;

  // Fixed state words
  localparam word_t CONST_SIX      = 32'h746C6F76;
  localparam word_t CONST_SEVEN    = 32'h61616461;
  localparam word_t CONST_FOURTEEN = 32'h72626173;
  localparam word_t CONST_FIFTEEN  = 32'h61636E61;

  // Rotation amounts of the quarter-round
  localparam logic [4:0] ROT_FIRST  = 5'd10;
  localparam logic [4:0] ROT_SECOND = 5'd27;
  localparam logic [4:0] ROT_THIRD  = 5'd8;

  // Rotate left by a nonzero amount
  function automatic word_t rotl(input word_t v, input logic [4:0] n);
    word_t res;
    res = (v << n) | (v >> (6'd32 - {1'b0, n}));
    return res;
  endfunction

  // Word index of operand pos (a..e) of quarter-round set sel.
  // Sets 0-3 are columns, sets 4-7 diagonals.
  function automatic widx_t qr_idx(input logic [2:0] sel, input logic [2:0] pos);
    logic [19:0] row;
    widx_t       res;
    case (sel)
      3'd0:    row = {4'd0, 4'd4, 4'd8,  4'd12, 4'd3};
      3'd1:    row = {4'd1, 4'd5, 4'd9,  4'd13, 4'd0};
      3'd2:    row = {4'd2, 4'd6, 4'd10, 4'd14, 4'd1};
      3'd3:    row = {4'd3, 4'd7, 4'd11, 4'd15, 4'd2};
      3'd4:    row = {4'd0, 4'd5, 4'd10, 4'd15, 4'd3};
      3'd5:    row = {4'd1, 4'd6, 4'd11, 4'd12, 4'd0};
      3'd6:    row = {4'd2, 4'd7, 4'd8,  4'd13, 4'd1};
      3'd7:    row = {4'd3, 4'd4, 4'd9,  4'd14, 4'd2};
      default: row = '0;
    endcase
    case (pos)
      3'd0:    res = row[19:16];
      3'd1:    res = row[15:12];
      3'd2:    res = row[11:8];
      3'd3:    res = row[7:4];
      3'd4:    res = row[3:0];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

[hdl/arx_subkey_derivation.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arx_subkey_derivation
// Derives a 256-bit subkey from a configured 256-bit key and a 128-bit
// nonce through a chain of pipelined ARX quarter-round cells.
//
//   channel  ports                            handshake
//   -------  -------------------------------  -------------------------------
//   input    in_nonce_word_zero..three        start & !busy
//   result   out_sub_word_zero..seven         out_valid strobe, one cycle
//   config   cfg_addr, cfg_wdata              cfg_we, taken every cycle
//
// One transaction enters per cycle while busy is low. The path is a load
// register, then 8*DOUBLE_ROUNDS cells of three register phases each. busy
// is high only during reset. The receiver cannot stall, so results stream
// out at the input rate. Reset clears the key registers and the pipeline
// valid bits.
// ----------------------------------------------------------------------------
module arx_subkey_derivation
  import arxsk_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = 7
) (
  input  wire              clk,
  input  wire              rst_n,
  // input channel
  input  wire              start,
  output logic             busy,
  input  wire [WORD_W-1:0] in_nonce_word_zero,
  input  wire [WORD_W-1:0] in_nonce_word_one,
  input  wire [WORD_W-1:0] in_nonce_word_two,
  input  wire [WORD_W-1:0] in_nonce_word_three,
  // result channel
  output logic             out_valid,
  output logic [WORD_W-1:0] out_sub_word_zero,
  output logic [WORD_W-1:0] out_sub_word_one,
  output logic [WORD_W-1:0] out_sub_word_two,
  output logic [WORD_W-1:0] out_sub_word_three,
  output logic [WORD_W-1:0] out_sub_word_four,
  output logic [WORD_W-1:0] out_sub_word_five,
  output logic [WORD_W-1:0] out_sub_word_six,
  output logic [WORD_W-1:0] out_sub_word_seven,
  // configuration port
  input  wire              cfg_we,
  input  wire [1:0]        cfg_addr,
  input  wire [KEY_W-1:0]  cfg_wdata
);

  localparam int unsigned NUM_CELLS = SETS_PER_DR * DOUBLE_ROUNDS;
  localparam int unsigned LATENCY   = 1 + 3 * NUM_CELLS;

  logic [KEY_W-1:0] key_a_r, key_b_r, key_c_r, key_d_r;
  logic             in_accept;
  logic             ld_vld_r;
  state_t           ld_st_r, ld_st_nxt;
  logic   [NUM_CELLS:0] chain_vld;
  state_t [NUM_CELLS:0] chain_st;

  assign busy      = ~rst_n;
  assign in_accept = start & ~busy;

  // Key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r <= '0;
      key_b_r <= '0;
      key_c_r <= '0;
      key_d_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_KEY_A: key_a_r <= cfg_wdata;
        CFG_KEY_B: key_b_r <= cfg_wdata;
        CFG_KEY_C: key_c_r <= cfg_wdata;
        CFG_KEY_D: key_d_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Initial state layout
  always_comb begin
    ld_st_nxt[0]  = key_a_r[31:0];
    ld_st_nxt[1]  = key_a_r[63:32];
    ld_st_nxt[2]  = key_b_r[31:0];
    ld_st_nxt[3]  = key_b_r[63:32];
    ld_st_nxt[4]  = in_nonce_word_zero;
    ld_st_nxt[5]  = in_nonce_word_one;
    ld_st_nxt[6]  = CONST_SIX;
    ld_st_nxt[7]  = CONST_SEVEN;
    ld_st_nxt[8]  = key_c_r[31:0];
    ld_st_nxt[9]  = key_c_r[63:32];
    ld_st_nxt[10] = key_d_r[31:0];
    ld_st_nxt[11] = key_d_r[63:32];
    ld_st_nxt[12] = in_nonce_word_two;
    ld_st_nxt[13] = in_nonce_word_three;
    ld_st_nxt[14] = CONST_FOURTEEN;
    ld_st_nxt[15] = CONST_FIFTEEN;
  end

  // Load stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_vld_r <= 1'b0;
    end else begin
      ld_vld_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    ld_st_r <= ld_st_nxt;
  end

  assign chain_vld[0] = ld_vld_r;
  assign chain_st[0]  = ld_st_r;

  // Quarter-round cell chain: columns then diagonals, repeated per double round
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    arxsk_qr_cell #(
      .SET_IDX (i % SETS_PER_DR)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (chain_vld[i]),
      .in_st   (chain_st[i]),
      .out_vld (chain_vld[i+1]),
      .out_st  (chain_st[i+1])
    );
  end

  // Result words, straight from the last cell's register
  assign out_valid          = chain_vld[NUM_CELLS];
  assign out_sub_word_zero  = chain_st[NUM_CELLS][4];
  assign out_sub_word_one   = chain_st[NUM_CELLS][5];
  assign out_sub_word_two   = chain_st[NUM_CELLS][6];
  assign out_sub_word_three = chain_st[NUM_CELLS][7];
  assign out_sub_word_four  = chain_st[NUM_CELLS][12];
  assign out_sub_word_five  = chain_st[NUM_CELLS][13];
  assign out_sub_word_six   = chain_st[NUM_CELLS][14];
  assign out_sub_word_seven = chain_st[NUM_CELLS][15];

`ifndef SYNTH
  // A result strobe always traces back to an accepted transaction
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, LATENCY))
    else $error("result strobe without matching input transaction");

  // Reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // No input transaction is taken during reset
  a_no_accept_in_reset: assert property (@(posedge clk)
    !rst_n |=> !ld_vld_r)
    else $error("load stage filled during reset");
`endif

endmodule
`default_nettype wire

[hdl/arxsk_qr_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arxsk_qr_cell
// One five-operand ARX quarter-round over the full state, split into three
// registered phases of two dependent adds each.
// ----------------------------------------------------------------------------
module arxsk_qr_cell
  import arxsk_pkg::*;
#(
  parameter int unsigned SET_IDX = 0
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_vld,
  input  wire state_t  in_st,
  output logic         out_vld,
  output state_t       out_st
);

  localparam logic [2:0] SEL = SET_IDX[2:0];
  localparam widx_t IA = qr_idx(SEL, 3'd0);
  localparam widx_t IB = qr_idx(SEL, 3'd1);
  localparam widx_t IC = qr_idx(SEL, 3'd2);
  localparam widx_t ID = qr_idx(SEL, 3'd3);
  localparam widx_t IE = qr_idx(SEL, 3'd4);

  logic   vld1_r, vld2_r, vld3_r;
  state_t st1_r, st2_r, st3_r;
  state_t st1_nxt, st2_nxt, st3_nxt;
  word_t  p1_d, p1_c, p2_a, p2_e, p3_c, p3_b;

  // Phase 1: d += e; c ^= d; b = rotl(b + c, 10)
  always_comb begin
    p1_d    = in_st[ID] + in_st[IE];
    p1_c    = in_st[IC] ^ p1_d;
    st1_nxt = in_st;
    st1_nxt[ID] = p1_d;
    st1_nxt[IC] = p1_c;
    st1_nxt[IB] = rotl(in_st[IB] + p1_c, ROT_FIRST);
  end

  // Phase 2: a += b; e ^= a; d = rotl(d + e, 27)
  always_comb begin
    p2_a    = st1_r[IA] + st1_r[IB];
    p2_e    = st1_r[IE] ^ p2_a;
    st2_nxt = st1_r;
    st2_nxt[IA] = p2_a;
    st2_nxt[IE] = p2_e;
    st2_nxt[ID] = rotl(st1_r[ID] + p2_e, ROT_SECOND);
  end

  // Phase 3: c += d; b ^= c; a = rotl(a + b, 8)
  always_comb begin
    p3_c    = st2_r[IC] + st2_r[ID];
    p3_b    = st2_r[IB] ^ p3_c;
    st3_nxt = st2_r;
    st3_nxt[IC] = p3_c;
    st3_nxt[IB] = p3_b;
    st3_nxt[IA] = rotl(st2_r[IA] + p3_b, ROT_THIRD);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    st1_r <= st1_nxt;
    st2_r <= st2_nxt;
    st3_r <= st3_nxt;
  end

  assign out_vld = vld3_r;
  assign out_st  = st3_r;

endmodule
`default_nettype wire
